[hdl/fbpa_pkg.sv]
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_BLOCKS  = 1024;
    localparam int ADDR_W      = 32;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W      = 16;
    localparam int CFG_COUNT_W = 11;
    localparam int SPAN_W      = IDX_W + SIZE_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(IDX_W + 1);

    localparam int CFG_BASE_RST  = 0;
    localparam int CFG_SIZE_RST  = 16;
    localparam int CFG_COUNT_RST = 1024;
    localparam int SPAN_RST      = CFG_COUNT_RST * CFG_SIZE_RST;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE  = 2'd0,
        CFG_SIZE  = 2'd1,
        CFG_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_REINIT = 2'd2,
        REQ_NOP    = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_RANGE     = 3'd2,
        ST_MISALIGN  = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_FREE      = 3'd1,
        CMD_RANGE_ERR = 3'd2,
        CMD_REINIT    = 3'd3,
        CMD_NOP       = 3'd4
    } cmd_kind_t;

    // normalized pool geometry: size at least one, count at most MAX_BLOCKS
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  count;
    } geo_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [SPAN_W-1:0] off;
    } cmd_t;

    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] link;
    } ram_entry_t;

endpackage

[hdl/fbpa_ram.sv]
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/fbpa_fifo.sv]
`timescale 1ns / 1ps

module fbpa_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fbpa_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output fbpa_pkg::cmd_t pop_data,
    output logic           empty
);
    import fbpa_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/fbpa_front.sv]
`timescale 1ns / 1ps

module fbpa_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fbpa_pkg::REQ_W-1:0]   s_req_type,
    input  logic [fbpa_pkg::ADDR_W-1:0]  s_free_addr,
    input  fbpa_pkg::geo_t               geo,
    output logic                         push,
    output fbpa_pkg::cmd_t               cmd,
    input  logic                         full
);
    import fbpa_pkg::*;

    // geometry as seen by the requests in order; reloaded when a reinit is taken
    logic [ADDR_W-1:0]       geo_base_reg, geo_base_next;
    logic [SPAN_W-1:0]       geo_span_reg, geo_span_next;
    logic [CNT_W+SIZE_W-1:0] span_full;
    logic [ADDR_W-1:0]       off;
    logic                    in_range;
    req_type_t               req;

    assign s_ready = !full;
    assign push    = s_valid && !full;
    assign req     = req_type_t'(s_req_type);

    always_comb begin
        off       = s_free_addr - geo_base_reg;
        in_range  = (off < ADDR_W'(geo_span_reg));
        span_full = (CNT_W + SIZE_W)'(geo.count) * (CNT_W + SIZE_W)'(geo.size);
        cmd.off   = off[SPAN_W-1:0];
        unique case (req)
            REQ_ALLOC:  cmd.kind = CMD_ALLOC;
            REQ_FREE:   cmd.kind = in_range ? CMD_FREE : CMD_RANGE_ERR;
            REQ_REINIT: cmd.kind = CMD_REINIT;
            REQ_NOP:    cmd.kind = CMD_NOP;
            default:    cmd.kind = CMD_NOP;
        endcase
        geo_base_next = geo_base_reg;
        geo_span_next = geo_span_reg;
        if (push && req == REQ_REINIT) begin
            geo_base_next = geo.base;
            geo_span_next = span_full[SPAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geo_base_reg <= ADDR_W'(CFG_BASE_RST);
            geo_span_reg <= SPAN_W'(SPAN_RST);
        end else begin
            geo_base_reg <= geo_base_next;
            geo_span_reg <= geo_span_next;
        end
    end

endmodule

[hdl/fbpa_back.sv]
`timescale 1ns / 1ps

module fbpa_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fbpa_pkg::geo_t                 geo,
    input  logic                           empty,
    input  fbpa_pkg::cmd_t                 cmd,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]  m_status,
    output logic [fbpa_pkg::ADDR_W-1:0]    m_block_addr,
    output logic [fbpa_pkg::CNT_W-1:0]     m_free_count
);
    import fbpa_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE    = 5'b00001,
        B_ALLOC   = 5'b00010,
        B_DIV     = 5'b00100,
        B_FREE_RD = 5'b01000,
        B_FREE    = 5'b10000
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     free_reg, free_next;
    // blocks below the watermark have been handed out since the last reinit,
    // so their memory entries are written; above it links are i+1, used clear
    logic [CNT_W-1:0]     wm_reg, wm_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [SPAN_W-1:0]    prod_reg, prod_next;
    logic [SPAN_W-1:0]    rem_reg, rem_next;
    logic [SPAN_W-1:0]    dsh_reg, dsh_next;
    logic [IDX_W-1:0]     q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]     fcnt_reg, fcnt_next;

    logic                 out_free;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    ram_entry_t           ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    ram_entry_t           ram_rdata;
    logic [$bits(ram_entry_t)-1:0] ram_rdata_raw;
    logic [IDX_W-1:0]     head_inc;
    logic                 head_fresh;
    logic                 ge;
    logic                 blk_used;

    fbpa_ram #(
        .WIDTH ($bits(ram_entry_t)),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata    = ram_entry_t'(ram_rdata_raw);
    assign out_free     = !m_valid_reg || m_ready;
    assign pop          = (state_reg == B_IDLE) && !empty && out_free;
    assign ram_raddr    = (state_reg == B_IDLE) ? head_reg : q_reg;
    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_block_addr = addr_reg;
    assign m_free_count = fcnt_reg;

    always_comb begin
        head_inc   = (head_reg == IDX_W'(MAX_BLOCKS - 1)) ? '0 : head_reg + 1'b1;
        head_fresh = ({1'b0, head_reg} >= wm_reg);
        ge         = (rem_reg >= dsh_reg);
        blk_used   = ({1'b0, q_reg} < wm_reg) && ram_rdata.used;

        state_next   = state_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        wm_next      = wm_reg;
        base_next    = base_reg;
        size_next    = size_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;
        fcnt_next    = fcnt_reg;
        ram_we       = 1'b0;
        ram_waddr    = head_reg;
        ram_wdata    = '0;

        unique case (state_reg)
            B_IDLE: begin
                if (pop) begin
                    unique case (cmd.kind)
                        CMD_ALLOC: begin
                            if (free_reg == '0) begin
                                m_valid_next = 1'b1;
                                status_next  = ST_NO_MEM;
                                addr_next    = '0;
                                fcnt_next    = free_reg;
                            end else begin
                                prod_next  = SPAN_W'(head_reg) * SPAN_W'(size_reg);
                                state_next = B_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            rem_next   = cmd.off;
                            dsh_next   = SPAN_W'(size_reg) << (IDX_W - 1);
                            q_next     = '0;
                            cnt_next   = DIV_CNT_W'(IDX_W - 1);
                            state_next = B_DIV;
                        end
                        CMD_RANGE_ERR: begin
                            m_valid_next = 1'b1;
                            status_next  = ST_RANGE;
                            addr_next    = '0;
                            fcnt_next    = free_reg;
                        end
                        CMD_REINIT: begin
                            base_next    = geo.base;
                            size_next    = geo.size;
                            head_next    = '0;
                            free_next    = geo.count;
                            wm_next      = '0;
                            m_valid_next = 1'b1;
                            status_next  = ST_OK;
                            addr_next    = '0;
                            fcnt_next    = geo.count;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            status_next  = ST_OK;
                            addr_next    = '0;
                            fcnt_next    = free_reg;
                        end
                    endcase
                end
            end
            B_ALLOC: begin
                ram_we         = 1'b1;
                ram_waddr      = head_reg;
                ram_wdata.used = 1'b1;
                ram_wdata.link = head_fresh ? head_inc : ram_rdata.link;
                if (head_fresh) begin
                    wm_next = CNT_W'(head_reg) + 1'b1;
                end
                head_next    = ram_wdata.link;
                free_next    = free_reg - 1'b1;
                m_valid_next = 1'b1;
                status_next  = ST_OK;
                addr_next    = base_reg + ADDR_W'(prod_reg);
                fcnt_next    = free_reg - 1'b1;
                state_next   = B_IDLE;
            end
            B_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_next = ge ? rem_reg - dsh_reg : rem_reg;
                q_next   = IDX_W'({q_reg, ge});
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == '0) begin
                    state_next = B_FREE_RD;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            B_FREE_RD: begin
                if (rem_reg != '0) begin
                    m_valid_next = 1'b1;
                    status_next  = ST_MISALIGN;
                    addr_next    = '0;
                    fcnt_next    = free_reg;
                    state_next   = B_IDLE;
                end else begin
                    state_next = B_FREE;
                end
            end
            B_FREE: begin
                m_valid_next = 1'b1;
                addr_next    = '0;
                if (!blk_used) begin
                    status_next = ST_NOT_ALLOC;
                    fcnt_next   = free_reg;
                end else begin
                    ram_we         = 1'b1;
                    ram_waddr      = q_reg;
                    ram_wdata.used = 1'b0;
                    ram_wdata.link = head_reg;
                    head_next      = q_reg;
                    free_next      = free_reg + 1'b1;
                    status_next    = ST_OK;
                    fcnt_next      = free_reg + 1'b1;
                end
                state_next = B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            head_reg    <= '0;
            free_reg    <= CNT_W'(CFG_COUNT_RST);
            wm_reg      <= '0;
            base_reg    <= ADDR_W'(CFG_BASE_RST);
            size_reg    <= SIZE_W'(CFG_SIZE_RST);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            free_reg    <= free_next;
            wm_reg      <= wm_next;
            base_reg    <= base_next;
            size_reg    <= size_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        q_reg      <= q_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        fcnt_reg   <= fcnt_next;
    end

endmodule

[hdl/fixed_block_pool_allocator_top.sv]
`timescale 1ns / 1ps
// Result path by kind: reinit, no-op, failed alloc and out-of-range free answer straight from
// idle; a good alloc first reads the link memory; an in-range free runs the restoring divider,
// then the used-bit read, and a misaligned one is answered after the divider without that read.
// The back end takes a new beat from the FIFO only when idle and its result register is free.
// Synchronous active-low reset: full free list of 1024 blocks, no clearing pass.

module fixed_block_pool_allocator_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [fbpa_pkg::REQ_W-1:0]       s_req_type,
    input  logic [fbpa_pkg::ADDR_W-1:0]      s_free_addr,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]    m_status,
    output logic [fbpa_pkg::ADDR_W-1:0]      m_block_addr,
    output logic [fbpa_pkg::CNT_W-1:0]       m_free_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fbpa_pkg::*;

    logic [ADDR_W-1:0]      cfg_base_reg, cfg_base_next;
    logic [SIZE_W-1:0]      cfg_size_reg, cfg_size_next;
    logic [CFG_COUNT_W-1:0] cfg_count_reg, cfg_count_next;
    geo_t                   geo;
    logic                   push;
    logic                   pop;
    logic                   full;
    logic                   empty;
    cmd_t                   push_cmd;
    cmd_t                   pop_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_base_next  = cfg_base_reg;
        cfg_size_next  = cfg_size_reg;
        cfg_count_next = cfg_count_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_BASE:  cfg_base_next  = cfg_data[ADDR_W-1:0];
                CFG_SIZE:  cfg_size_next  = cfg_data[SIZE_W-1:0];
                CFG_COUNT: cfg_count_next = cfg_data[CFG_COUNT_W-1:0];
                default:   cfg_base_next  = cfg_base_reg;
            endcase
        end
        geo.base  = cfg_base_reg;
        geo.size  = (cfg_size_reg == '0) ? SIZE_W'(1) : cfg_size_reg;
        geo.count = (cfg_count_reg > CFG_COUNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : CNT_W'(cfg_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_base_reg  <= ADDR_W'(CFG_BASE_RST);
            cfg_size_reg  <= SIZE_W'(CFG_SIZE_RST);
            cfg_count_reg <= CFG_COUNT_W'(CFG_COUNT_RST);
        end else begin
            cfg_base_reg  <= cfg_base_next;
            cfg_size_reg  <= cfg_size_next;
            cfg_count_reg <= cfg_count_next;
        end
    end

    fbpa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_free_addr (s_free_addr),
        .geo         (geo),
        .push        (push),
        .cmd         (push_cmd),
        .full        (full)
    );

    fbpa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .empty     (empty)
    );

    fbpa_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .geo          (geo),
        .empty        (empty),
        .cmd          (pop_cmd),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_block_addr (m_block_addr),
        .m_free_count (m_free_count)
    );

endmodule

[hdl/fbpa_checker.sv]
`timescale 1ns / 1ps

module fbpa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [fbpa_pkg::STATUS_W-1:0] m_status,
    input logic [fbpa_pkg::ADDR_W-1:0]   m_block_addr,
    input logic [fbpa_pkg::CNT_W-1:0]    m_free_count
);
    import fbpa_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_block_addr)
                                && $stable(m_free_count))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= STATUS_W'(ST_NOT_ALLOC)))
        else $error("undefined status code");

    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_W'(ST_OK) |-> m_block_addr == '0)
        else $error("block address on a failed request");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_free_count <= CNT_W'(MAX_BLOCKS))
        else $error("free count beyond pool size");

    // no free block reported means nothing was left before the request
    a_nomem_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_W'(ST_NO_MEM) |-> m_free_count == '0)
        else $error("no-memory status with free blocks left");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_block_addr (m_block_addr),
    .m_free_count (m_free_count)
);
